/* src/ckbc_pkg.sv */
package ckbc_pkg;

	// Register map of the configuration port
	typedef enum logic [0:0] {
		REG_KEY_SEED     = 1'b0,
		REG_COUNTER_SEED = 1'b1
	} reg_index_t;

	localparam logic [7:0] KEY_SEED_RESET     = 8'hB2;
	localparam logic [7:0] COUNTER_SEED_RESET = 8'h28;

	localparam logic [7:0] MASK_LOW  = 8'hFE;
	localparam logic [7:0] MASK_MID  = 8'hFC;
	localparam logic [7:0] MASK_HIGH = 8'hFF;

	// Reciprocal of nine, scaled by 2^9; exact quotient for any 8-bit value
	localparam logic [5:0] RECIP_NINE = 6'd57;

	// Stage one payload handed to the output stage
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] ctr;
	} stage_t;

	// Rewrite the counter bit by bit, in the order 7, 0, 1 .. 6
	function automatic logic [7:0] scramble(input logic [7:0] ctr, input logic [7:0] key);
		logic [7:0] c;
		logic [2:0] p;
		logic [2:0] q;
		c = ctr;
		for (int step = 0; step < 8; step++) begin
			p = 3'(step + 7);
			q = key[p] ? 3'(p + 3'd1) : 3'(p + 3'd2);
			c[p] = c[p] ^ c[q];
		end
		return c;
	endfunction

	// Counter mod 9 by multiply with the scaled reciprocal
	function automatic logic [3:0] mod_nine(input logic [7:0] x);
		logic [13:0] prod;
		logic [4:0]  quo;
		logic [8:0]  tens;
		prod = 14'(x) * 14'(RECIP_NINE);
		quo  = prod[13:9];
		tens = 9'(quo) * 9'd9;
		return 4'(9'(x) - tens);
	endfunction

	function automatic logic [7:0] pick_mask(input logic [7:0] ctr);
		logic [3:0] m;
		m = mod_nine(ctr);
		if (m < 4'd3) begin
			return MASK_LOW;
		end else if (m < 4'd6) begin
			return MASK_MID;
		end
		return MASK_HIGH;
	endfunction

endpackage

/* src/ckbc_state.sv */
module ckbc_state
	import ckbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       restart,
	output stage_t     stage_s1
);

	logic [7:0] key_seed_q;
	logic [7:0] counter_seed_q;
	logic [7:0] key_q;
	logic [7:0] ctr_q;
	logic [7:0] key_cur;
	logic [7:0] ctr_cur;
	logic [7:0] ctr_next;

	// Hold the seed registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_seed_q     <= KEY_SEED_RESET;
			counter_seed_q <= COUNTER_SEED_RESET;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_KEY_SEED:     key_seed_q     <= cfg_data;
				REG_COUNTER_SEED: counter_seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pick live state or reload from seeds, then scramble and bump
	always_comb begin
		key_cur  = restart ? key_seed_q : key_q;
		ctr_cur  = restart ? counter_seed_q : ctr_q;
		ctr_next = scramble(ctr_cur, key_cur) + 8'd1;
	end

	// Advance key and counter once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_SEED_RESET;
			ctr_q <= COUNTER_SEED_RESET;
		end else if (accept) begin
			key_q <= key_cur + 8'd1;
			ctr_q <= ctr_next;
		end
	end

	// Capture the beat with its new counter
	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.data <= data_byte;
			stage_s1.ctr  <= ctr_next;
		end
	end

endmodule

/* src/ckbc_outreg.sv */
module ckbc_outreg
	import ckbc_pkg::*;
(
	input  logic       clk,
	input  stage_t     stage_s1,
	input  logic       load,
	output logic [7:0] out_byte
);

	logic [7:0] keystream;

	// Mask the counter by its residue class
	assign keystream = stage_s1.ctr & pick_mask(stage_s1.ctr);

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte <= stage_s1.data ^ keystream;
		end
	end

endmodule

/* src/counter_keystream_byte_cipher.sv */
// Channel | signals                              | direction
// --------+--------------------------------------+----------
// input   | in_valid, in_stall, data_byte, restart | in (stall out)
// output  | out_valid, out_stall, out_byte       | out (stall in)
// config  | cfg_we, cfg_index, cfg_data          | in
//
// One byte per cycle while the output is not stalled; an accepted byte passes stage one, then the output register.
// Key and counter advance at the accept edge, so the next accepted byte already sees the new state.
// Reset loads seeds 0xB2 / 0x28 and both state registers from them.
// An output stall holds the result; input stalls only when both stages are full
// and the output is stalled.
module counter_keystream_byte_cipher
	import ckbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       restart,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte
);

	stage_t stage_s1;
	logic   valid_s1;
	logic   valid_q;
	logic   accept;
	logic   adv_out;
	logic   load_out;

	// Handshake: output register frees when empty or taken
	assign adv_out  = !valid_q || !out_stall;
	assign load_out = valid_s1 && adv_out;
	assign in_stall = valid_s1 && !adv_out;
	assign accept   = in_valid && !in_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv_out);
			if (adv_out) begin
				valid_q <= valid_s1;
			end
		end
	end

	ckbc_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.data_byte (data_byte),
		.restart   (restart),
		.stage_s1  (stage_s1)
	);

	ckbc_outreg u_outreg (
		.clk      (clk),
		.stage_s1 (stage_s1),
		.load     (load_out),
		.out_byte (out_byte)
	);

endmodule

/* src/ckbc_checker.sv */
module ckbc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte
);

	// Stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte))
		else $error("output beat changed under stall");

	// Input never stalls while the output register is empty
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// Accepted beat passes stage one and then shows up at the output when the sink keeps taking
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_stall) ##1 !out_stall |=> out_valid)
		else $error("result missing two cycles after accept");

	// A fresh result needs an accepted input beat behind it in stage one
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without input beat");

endmodule

bind counter_keystream_byte_cipher ckbc_checker u_ckbc_checker (.*);
